// ===== rtl/core/cdsr_pkg.sv =====
// Shared types and constants for the circular deque with sort and reverse.
`timescale 1ns / 1ps
package cdsr_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned CNT_OUT_W    = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_REAR  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_REAR  = 3'd3,
    ACT_REVERSE   = 3'd4,
    ACT_SORT      = 3'd5,
    ACT_DUMP      = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic                     last;
    logic [CNT_OUT_W-1:0]     count;
  } res_t;

endpackage

// ===== rtl/core/cdsr_in_if.sv =====
// Request channel: action and value with valid/ready.
`timescale 1ns / 1ps
interface cdsr_in_if import cdsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== rtl/core/cdsr_out_if.sv =====
// Result channel: data, status, last flag and count with valid/ready.
`timescale 1ns / 1ps
interface cdsr_out_if import cdsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [1:0]               status;
  logic                     last;
  logic [CNT_OUT_W-1:0]     count;

  modport source (output valid, output data_out, output status, output last, output count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input last, input count,
                  output ready);
endinterface

// ===== rtl/core/circular_deque_sort_reverse_top.sv =====
// Top level of the circular deque with sort and reverse.
// Inserts and deletes each give one result; a dump gives one entry a cycle while the output register is free.
// Reverse of n >= 2 entries swaps pairs from both ends inward; sort runs bubble passes until a
// pass makes no swap, up to n passes; with fewer than two entries either just returns a result.
// The entry store has a single read port and a single write port.
// One request is in flight at a time; a new request is taken while a result waits at the output.
// Reset clears pointers, count and control; the entry store holds no reset and needs no sweep.
`timescale 1ns / 1ps
module circular_deque_sort_reverse_top import cdsr_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdsr_in_if.sink     in_i,
  cdsr_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  logic                     mem_re, mem_we;
  logic [IW-1:0]            mem_raddr, mem_waddr;
  logic signed [DATA_W-1:0] mem_rdata, mem_wdata;
  logic                     res_free, res_push;
  res_t                     res;

  cdsr_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .res_free_i  (res_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  cdsr_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  cdsr_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res),
    .free_o (res_free),
    .out_o  (out_o)
  );

  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("read and write to the same entry in one cycle");

  a_push_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> res_free)
    else $error("result pushed while output register is occupied");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!mem_we && !res_push))
    else $error("store write or result while taking a new request");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken without leaving idle");

endmodule

// ===== rtl/core/cdsr_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module cdsr_mem import cdsr_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic signed [DATA_W-1:0]         rdata_o,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic signed [DATA_W-1:0]         wdata_i
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cdsr_obuf.sv =====
// Result register between the sequencer and the result channel.
`timescale 1ns / 1ps
module cdsr_obuf import cdsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  res_t              res_i,
  output logic              free_o,
  cdsr_out_if.source        out_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.data_out = res_q.data;
  assign out_o.status   = res_q.status;
  assign out_o.last     = res_q.last;
  assign out_o.count    = res_q.count;

endmodule

// ===== rtl/core/cdsr_seq.sv =====
// Sequencer: ring pointers, action decode and read-modify-write walks of the store.
`timescale 1ns / 1ps
module cdsr_seq import cdsr_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cdsr_in_if.sink                          in_i,
  output logic                             mem_re_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr_o,
  input  logic signed [DATA_W-1:0]         mem_rdata_i,
  output logic                             mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr_o,
  output logic signed [DATA_W-1:0]         mem_wdata_o,
  input  logic                             res_free_i,
  output logic                             res_push_o,
  output res_t                             res_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_EXEC      = 12'b0000_0000_0010,
    S_DEL       = 12'b0000_0000_0100,
    S_REV_A     = 12'b0000_0000_1000,
    S_REV_B     = 12'b0000_0001_0000,
    S_REV_W1    = 12'b0000_0010_0000,
    S_REV_W2    = 12'b0000_0100_0000,
    S_SORT_LOAD = 12'b0000_1000_0000,
    S_SORT_CMP  = 12'b0001_0000_0000,
    S_SORT_END  = 12'b0010_0000_0000,
    S_DUMP      = 12'b0100_0000_0000,
    S_FIN       = 12'b1000_0000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic [IW-1:0]            head_q, head_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [IW-1:0]            ptr_q, ptr_d;
  logic [IW-1:0]            hi_q, hi_d;
  logic signed [DATA_W-1:0] tmp_q, tmp_d;
  logic                     swp_q, swp_d;
  logic [ACT_W-1:0]         act_q;
  logic signed [DATA_W-1:0] val_q;

  logic [IW-1:0] roff, woff;
  logic [CW-1:0] cnt_m1, cnt_p1;
  logic          full, empty, few, is_end;

  function automatic logic [IW-1:0] ring(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign cnt_m1 = cnt_q - 1'b1;
  assign cnt_p1 = cnt_q + 1'b1;
  assign full   = (cnt_q == CW'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign few    = (cnt_q < CW'(2));
  assign is_end = (CW'(ptr_q) == cnt_m1);

  assign in_i.ready  = (state_q == S_IDLE);
  assign mem_raddr_o = ring(head_q, roff);
  assign mem_waddr_o = ring(head_q, woff);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    hi_d        = hi_q;
    tmp_d       = tmp_q;
    swp_d       = swp_q;
    mem_re_o    = 1'b0;
    roff        = '0;
    mem_we_o    = 1'b0;
    woff        = '0;
    mem_wdata_o = val_q;
    res_push_o  = 1'b0;
    res_o       = '{data: '0, status: ST_OK, last: 1'b1, count: CNT_OUT_W'(cnt_q)};

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (act_q)
          ACT_INS_FRONT, ACT_INS_REAR: begin
            if (res_free_i) begin
              res_push_o = 1'b1;
              state_d    = S_IDLE;
              if (full) begin
                res_o.status = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                woff        = (act_q == ACT_INS_FRONT) ? IW'(CAPACITY - 1) : cnt_q[IW-1:0];
                cnt_d       = cnt_p1;
                res_o.count = CNT_OUT_W'(cnt_p1);
                if (act_q == ACT_INS_FRONT) begin
                  head_d = mem_waddr_o;
                end
              end
            end
          end
          ACT_DEL_FRONT, ACT_DEL_REAR: begin
            if (empty) begin
              if (res_free_i) begin
                res_push_o   = 1'b1;
                res_o.status = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              mem_re_o = 1'b1;
              roff     = (act_q == ACT_DEL_FRONT) ? '0 : cnt_m1[IW-1:0];
              state_d  = S_DEL;
            end
          end
          ACT_REVERSE: begin
            if (few) begin
              state_d = S_FIN;
            end else begin
              ptr_d   = '0;
              hi_d    = cnt_m1[IW-1:0];
              state_d = S_REV_A;
            end
          end
          ACT_SORT: begin
            if (few) begin
              state_d = S_FIN;
            end else begin
              mem_re_o = 1'b1;
              roff     = '0;
              swp_d    = 1'b0;
              state_d  = S_SORT_LOAD;
            end
          end
          ACT_DUMP: begin
            if (empty) begin
              if (res_free_i) begin
                res_push_o   = 1'b1;
                res_o.status = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              mem_re_o = 1'b1;
              roff     = '0;
              ptr_d    = '0;
              state_d  = S_DUMP;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      S_DEL: begin
        if (res_free_i) begin
          res_push_o  = 1'b1;
          res_o.data  = mem_rdata_i;
          res_o.count = CNT_OUT_W'(cnt_m1);
          cnt_d       = cnt_m1;
          if (act_q == ACT_DEL_FRONT) begin
            head_d = ring(head_q, IW'(1));
          end
          state_d = S_IDLE;
        end
      end

      S_REV_A: begin
        if (ptr_q < hi_q) begin
          mem_re_o = 1'b1;
          roff     = ptr_q;
          state_d  = S_REV_B;
        end else begin
          state_d = S_FIN;
        end
      end

      S_REV_B: begin
        mem_re_o = 1'b1;
        roff     = hi_q;
        tmp_d    = mem_rdata_i;
        state_d  = S_REV_W1;
      end

      S_REV_W1: begin
        mem_we_o    = 1'b1;
        woff        = ptr_q;
        mem_wdata_o = mem_rdata_i;
        state_d     = S_REV_W2;
      end

      S_REV_W2: begin
        mem_we_o    = 1'b1;
        woff        = hi_q;
        mem_wdata_o = tmp_q;
        ptr_d       = ptr_q + 1'b1;
        hi_d        = hi_q - 1'b1;
        state_d     = S_REV_A;
      end

      S_SORT_LOAD: begin
        tmp_d    = mem_rdata_i;
        mem_re_o = 1'b1;
        roff     = IW'(1);
        ptr_d    = IW'(1);
        state_d  = S_SORT_CMP;
      end

      // tmp_q carries the element bubbling toward the tail; its slot is written at pass end
      S_SORT_CMP: begin
        mem_we_o = 1'b1;
        woff     = ptr_q - 1'b1;
        if (tmp_q > mem_rdata_i) begin
          mem_wdata_o = mem_rdata_i;
          swp_d       = 1'b1;
        end else begin
          mem_wdata_o = tmp_q;
          tmp_d       = mem_rdata_i;
        end
        if (is_end) begin
          state_d = S_SORT_END;
        end else begin
          mem_re_o = 1'b1;
          roff     = ptr_q + 1'b1;
          ptr_d    = ptr_q + 1'b1;
        end
      end

      S_SORT_END: begin
        mem_we_o    = 1'b1;
        woff        = cnt_m1[IW-1:0];
        mem_wdata_o = tmp_q;
        if (swp_q) begin
          swp_d    = 1'b0;
          mem_re_o = 1'b1;
          roff     = '0;
          state_d  = S_SORT_LOAD;
        end else begin
          state_d = S_FIN;
        end
      end

      S_DUMP: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          res_o.data = mem_rdata_i;
          res_o.last = is_end;
          if (is_end) begin
            state_d = S_IDLE;
          end else begin
            mem_re_o = 1'b1;
            roff     = ptr_q + 1'b1;
            ptr_d    = ptr_q + 1'b1;
          end
        end
      end

      S_FIN: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      ptr_q   <= '0;
      hi_q    <= '0;
      swp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      hi_q    <= hi_d;
      swp_q   <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.action;
      val_q <= in_i.value;
    end
  end

endmodule
